// ===== design/limit_order_book_update_defines.svh =====
// Assertion macros for the order book block
`ifndef LIMIT_ORDER_BOOK_UPDATE_DEFINES_SVH
`define LIMIT_ORDER_BOOK_UPDATE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define LOB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lob check failed");

// Next-cycle implication checked outside reset
`define LOB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lob check failed");

`endif

// ===== design/lob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// Types and codes shared by the order book block.
// ----------------------------------------------------------------------------
package lob_pkg;

	// event kinds
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MODIFY = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_EXECUTE = 2'd3;

	// result status codes
	localparam logic [2:0] ST_APPLIED = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_MISSING = 3'd2;
	localparam logic [2:0] ST_BADQTY = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;
	localparam logic [2:0] ST_UPMOD = 3'd5;
	localparam logic [2:0] ST_CAPACITY = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OSCAN,    // scan order table: key match and first free slot
		S_OSCAN_W,  // last order read in flight
		S_DECIDE,   // checks on the order found
		S_LSCAN,    // scan levels of one side for price and first free level
		S_LSCAN_W,
		S_APPLY,    // write order and level entries
		S_BSCAN,    // scan all levels for best bid and ask
		S_BSCAN_W,
		S_DONE
	} state_t;

endpackage

// ===== design/limit_order_book_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_update
// Order table and per-side price levels with top-of-book report.
// ----------------------------------------------------------------------------
// Pulse start with an event while busy is low; busy stays high until the
// single result appears with done high for one cycle, and the result must be
// taken in that cycle. The level scan and write are skipped when the order
// checks reject the event or it is a modify to the same quantity. busy drops
// in the cycle after the result, so a new event is taken only once the last
// one is done. The time goes in a linear scan of the order memory, one of the
// event side's level memory, then a pass over both sides for the best levels
// (the level count rounded up to a power of two), each one entry per cycle
// through a single read port. No clearing pass after reset: used bits live
// in flip-flops.
module limit_order_book_update #(
	parameter int ORDER_SLOTS = 256,
	parameter int LEVEL_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  mode,
	input  logic [63:0] order_ident,
	input  logic        order_side,
	input  logic [31:0] price_ticks,
	input  logic [31:0] amount,
	output logic [2:0]  status,
	output logic        bid_valid,
	output logic [31:0] bid_price,
	output logic [39:0] bid_total,
	output logic [8:0]  bid_orders,
	output logic        ask_valid,
	output logic [31:0] ask_price,
	output logic [39:0] ask_total,
	output logic [8:0]  ask_orders,
	output logic [63:0] applied_count,
	output logic [8:0]  live_orders
);

	`include "limit_order_book_update_defines.svh"

	localparam int OW = $clog2(ORDER_SLOTS);
	localparam int LW = $clog2(2 * LEVEL_SLOTS);
	localparam int LSW = $clog2(LEVEL_SLOTS);
	localparam int CW = $clog2(ORDER_SLOTS + 1);
	localparam int LVLS = 2 ** LW;
	localparam int IW = ((OW > LW) ? OW : LW) + 1;

	lob_pkg::state_t state_q, state_d;

	// latched event
	logic [1:0]  mode_q;
	logic [63:0] id_q;
	logic        side_q;
	logic [31:0] price_q;
	logic [31:0] amt_q;

	// order memory
	logic                 o_used_q [ORDER_SLOTS];
	logic [63:0]          o_key_m  [ORDER_SLOTS];
	logic                 o_side_m [ORDER_SLOTS];
	logic [31:0]          o_price_m[ORDER_SLOTS];
	logic [31:0]          o_amt_m  [ORDER_SLOTS];
	logic [63:0]          o_key_rd;
	logic                 o_side_rd;
	logic [31:0]          o_price_rd;
	logic [31:0]          o_amt_rd;
	logic                 o_used_rd;

	// level memory (bids low half, asks high half)
	logic                 l_used_q [LVLS];
	logic [31:0]          l_price_m[LVLS];
	logic [39:0]          l_total_m[LVLS];
	logic [CW-1:0]        l_cnt_m  [LVLS];
	logic [31:0]          l_price_rd;
	logic [39:0]          l_total_rd;
	logic [CW-1:0]        l_cnt_rd;
	logic                 l_used_rd;

	// scan control
	logic [IW-1:0] idx_q;     // issue index, wide enough to hold either depth
	logic [IW-2:0] ridx_q;    // index of the data now on the read port
	logic          rvld_q;

	// order scan results
	logic          hit_q, free_q;
	logic [OW-1:0] hit_slot_q, free_slot_q;
	logic          hit_side_q;
	logic [31:0]   hit_price_q, hit_amt_q;

	// level scan results
	logic          lhit_q, lfree_q;
	logic [LW-1:0] lhit_q_idx, lfree_q_idx;
	logic [39:0]   lhit_total_q;
	logic [CW-1:0] lhit_cnt_q;

	// best-level trackers
	logic          bb_v_q, ba_v_q;
	logic [31:0]   bb_p_q, ba_p_q;
	logic [39:0]   bb_t_q, ba_t_q;
	logic [CW-1:0] bb_c_q, ba_c_q;

	logic [2:0]    st_q;
	logic [63:0]   evt_q;
	logic [CW-1:0] live_q;
	logic          done_q;

	// what the decide step settles
	logic [2:0]    dec_st;
	logic          dec_remove;  // order leaves the book
	logic [31:0]   dec_take;    // quantity off the level

	// level scan side and price
	logic          ls_side;
	logic [31:0]   ls_price;
	assign ls_side  = (mode_q == lob_pkg::MODE_ADD) ? side_q  : hit_side_q;
	assign ls_price = (mode_q == lob_pkg::MODE_ADD) ? price_q : hit_price_q;

	logic [LW-1:0] lvl_addr;
	assign lvl_addr = (state_q == lob_pkg::S_BSCAN) ? idx_q[LW-1:0]
		: {ls_side, idx_q[LSW-1:0]};

	logic idx_last_o, idx_last_l, idx_last_b;
	assign idx_last_o = (idx_q[OW-1:0] == OW'(ORDER_SLOTS - 1));
	assign idx_last_l = (idx_q[LSW-1:0] == LSW'(LEVEL_SLOTS - 1));
	assign idx_last_b = (idx_q[LW-1:0] == LW'(LVLS - 1));

	// ------------------------------------------------------------------
	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lob_pkg::S_IDLE: if (start) state_d = lob_pkg::S_OSCAN;
			lob_pkg::S_OSCAN: if (idx_last_o) state_d = lob_pkg::S_OSCAN_W;
			lob_pkg::S_OSCAN_W: state_d = lob_pkg::S_DECIDE;
			lob_pkg::S_DECIDE: begin
				if (dec_st != lob_pkg::ST_APPLIED) state_d = lob_pkg::S_BSCAN;
				else if (mode_q == lob_pkg::MODE_MODIFY && dec_take == 32'd0)
					state_d = lob_pkg::S_BSCAN;
				else state_d = lob_pkg::S_LSCAN;
			end
			lob_pkg::S_LSCAN: if (idx_last_l) state_d = lob_pkg::S_LSCAN_W;
			lob_pkg::S_LSCAN_W: state_d = lob_pkg::S_APPLY;
			lob_pkg::S_APPLY: state_d = lob_pkg::S_BSCAN;
			lob_pkg::S_BSCAN: if (idx_last_b) state_d = lob_pkg::S_BSCAN_W;
			lob_pkg::S_BSCAN_W: state_d = lob_pkg::S_DONE;
			lob_pkg::S_DONE: state_d = lob_pkg::S_IDLE;
			default: state_d = lob_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs of the sequencer
	always_comb begin
		busy = (state_q != lob_pkg::S_IDLE);
	end

	// ------------------------------------------------------------------
	// Decide: status from the order scan
	always_comb begin
		dec_st = lob_pkg::ST_APPLIED;
		dec_remove = 1'b0;
		dec_take = 32'd0;
		case (mode_q)
			lob_pkg::MODE_ADD: begin
				if (amt_q == 32'd0) dec_st = lob_pkg::ST_BADQTY;
				else if (hit_q) dec_st = lob_pkg::ST_DUP;
				else if (!free_q) dec_st = lob_pkg::ST_CAPACITY;
			end
			lob_pkg::MODE_MODIFY: begin
				if (amt_q == 32'd0) dec_st = lob_pkg::ST_BADQTY;
				else if (!hit_q) dec_st = lob_pkg::ST_MISSING;
				else if (amt_q > hit_amt_q) dec_st = lob_pkg::ST_UPMOD;
				else dec_take = hit_amt_q - amt_q;
			end
			lob_pkg::MODE_CANCEL: begin
				if (!hit_q) dec_st = lob_pkg::ST_MISSING;
				else begin
					dec_remove = 1'b1;
					dec_take = hit_amt_q;
				end
			end
			default: begin
				if (amt_q == 32'd0) dec_st = lob_pkg::ST_BADQTY;
				else if (!hit_q) dec_st = lob_pkg::ST_MISSING;
				else if (amt_q > hit_amt_q) dec_st = lob_pkg::ST_SHORT;
				else begin
					dec_remove = (amt_q == hit_amt_q);
					dec_take = amt_q;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Memory read ports (registered)
	always_ff @(posedge clk) begin
		o_key_rd   <= o_key_m[idx_q[OW-1:0]];
		o_side_rd  <= o_side_m[idx_q[OW-1:0]];
		o_price_rd <= o_price_m[idx_q[OW-1:0]];
		o_amt_rd   <= o_amt_m[idx_q[OW-1:0]];
		l_price_rd <= l_price_m[lvl_addr];
		l_total_rd <= l_total_m[lvl_addr];
		l_cnt_rd   <= l_cnt_m[lvl_addr];
	end

	// apply-step values; a level total always covers its orders, so the
	// reduction never goes below zero
	logic [39:0]   lv_total_red;
	logic [39:0]   new_total;
	logic [CW-1:0] new_cnt;
	logic          lv_ok;
	logic [LW-1:0] lv_idx;
	always_comb begin
		lv_total_red = lhit_total_q - {8'd0, dec_take};
		lv_ok = 1'b1;
		lv_idx = lhit_q_idx;
		new_total = lv_total_red;
		new_cnt = lhit_cnt_q;
		if (mode_q == lob_pkg::MODE_ADD) begin
			if (lhit_q) begin
				new_total = lhit_total_q + {8'd0, amt_q};
				new_cnt = lhit_cnt_q + CW'(1);
			end else begin
				lv_ok = lfree_q;
				lv_idx = lfree_q_idx;
				new_total = {8'd0, amt_q};
				new_cnt = CW'(1);
			end
		end else if (dec_remove) begin
			new_cnt = (lhit_cnt_q != '0) ? lhit_cnt_q - CW'(1) : '0;
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == lob_pkg::S_APPLY) begin
			if (mode_q == lob_pkg::MODE_ADD) begin
				if (lv_ok) begin
					o_key_m[free_slot_q]   <= id_q;
					o_side_m[free_slot_q]  <= side_q;
					o_price_m[free_slot_q] <= price_q;
					o_amt_m[free_slot_q]   <= amt_q;
					l_price_m[lv_idx] <= price_q;
					l_total_m[lv_idx] <= new_total;
					l_cnt_m[lv_idx]   <= new_cnt;
				end
			end else begin
				if (!dec_remove) o_amt_m[hit_slot_q] <= hit_amt_q - dec_take;
				if (lhit_q) begin
					l_total_m[lv_idx] <= new_total;
					l_cnt_m[lv_idx]   <= new_cnt;
				end
			end
		end
	end

	// used bits, read alongside the memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER_SLOTS; i++) o_used_q[i] <= 1'b0;
			for (int i = 0; i < LVLS; i++) l_used_q[i] <= 1'b0;
			o_used_rd <= 1'b0;
			l_used_rd <= 1'b0;
		end else begin
			o_used_rd <= o_used_q[idx_q[OW-1:0]];
			l_used_rd <= l_used_q[lvl_addr];
			if (state_q == lob_pkg::S_APPLY) begin
				if (mode_q == lob_pkg::MODE_ADD) begin
					if (lv_ok) begin
						o_used_q[free_slot_q] <= 1'b1;
						l_used_q[lv_idx] <= 1'b1;
					end
				end else if (dec_remove) begin
					o_used_q[hit_slot_q] <= 1'b0;
					if (lhit_q && new_cnt == '0) l_used_q[lv_idx] <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer registers and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lob_pkg::S_IDLE;
			idx_q <= '0;
			ridx_q <= '0;
			rvld_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			lhit_q <= 1'b0;
			lfree_q <= 1'b0;
			bb_v_q <= 1'b0;
			ba_v_q <= 1'b0;
			evt_q <= '0;
			live_q <= '0;
			done_q <= 1'b0;
			st_q <= lob_pkg::ST_APPLIED;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == lob_pkg::S_BSCAN_W);
			ridx_q <= idx_q[IW-2:0];
			rvld_q <= (state_q == lob_pkg::S_OSCAN) || (state_q == lob_pkg::S_LSCAN)
				|| (state_q == lob_pkg::S_BSCAN);
			case (state_q)
				lob_pkg::S_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					lhit_q <= 1'b0;
					lfree_q <= 1'b0;
					bb_v_q <= 1'b0;
					ba_v_q <= 1'b0;
				end
				lob_pkg::S_OSCAN: idx_q <= idx_q + 1'b1;
				lob_pkg::S_DECIDE: begin
					idx_q <= '0;
					st_q <= dec_st;
				end
				lob_pkg::S_LSCAN: idx_q <= idx_q + 1'b1;
				lob_pkg::S_APPLY: begin
					idx_q <= '0;
					if (mode_q == lob_pkg::MODE_ADD && !lv_ok) st_q <= lob_pkg::ST_CAPACITY;
					else begin
						evt_q <= evt_q + 64'd1;
						if (mode_q == lob_pkg::MODE_ADD) live_q <= live_q + CW'(1);
						else if (dec_remove && live_q != '0) live_q <= live_q - CW'(1);
					end
				end
				lob_pkg::S_BSCAN: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
			// equal-quantity modify skips the level work but counts
			if (state_q == lob_pkg::S_DECIDE && dec_st == lob_pkg::ST_APPLIED
				&& mode_q == lob_pkg::MODE_MODIFY && dec_take == 32'd0)
				evt_q <= evt_q + 64'd1;
			// order table compare, one entry per cycle
			if (rvld_q && (state_q == lob_pkg::S_OSCAN || state_q == lob_pkg::S_OSCAN_W)) begin
				if (o_used_rd && o_key_rd == id_q && !hit_q) begin
					hit_q <= 1'b1;
					hit_slot_q <= ridx_q[OW-1:0];
					hit_side_q <= o_side_rd;
					hit_price_q <= o_price_rd;
					hit_amt_q <= o_amt_rd;
				end
				if (!o_used_rd && !free_q) begin
					free_q <= 1'b1;
					free_slot_q <= ridx_q[OW-1:0];
				end
			end
			// level compare for the event side
			if (rvld_q && (state_q == lob_pkg::S_LSCAN || state_q == lob_pkg::S_LSCAN_W)) begin
				if (l_used_rd && l_price_rd == ls_price && !lhit_q) begin
					lhit_q <= 1'b1;
					lhit_q_idx <= {ls_side, ridx_q[LSW-1:0]};
					lhit_total_q <= l_total_rd;
					lhit_cnt_q <= l_cnt_rd;
				end
				if (!l_used_rd && !lfree_q) begin
					lfree_q <= 1'b1;
					lfree_q_idx <= {ls_side, ridx_q[LSW-1:0]};
				end
			end
			// best level tracking, bids then asks
			if (rvld_q && l_used_rd
				&& (state_q == lob_pkg::S_BSCAN || state_q == lob_pkg::S_BSCAN_W)) begin
				if (!ridx_q[LW-1]) begin
					if (!bb_v_q || l_price_rd > bb_p_q) begin
						bb_v_q <= 1'b1;
						bb_p_q <= l_price_rd;
						bb_t_q <= l_total_rd;
						bb_c_q <= l_cnt_rd;
					end
				end else if (!ba_v_q || l_price_rd < ba_p_q) begin
					ba_v_q <= 1'b1;
					ba_p_q <= l_price_rd;
					ba_t_q <= l_total_rd;
					ba_c_q <= l_cnt_rd;
				end
			end
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mode;
			id_q <= order_ident;
			side_q <= order_side;
			price_q <= price_ticks;
			amt_q <= amount;
		end
	end

	// ------------------------------------------------------------------
	// Result ports
	assign done = done_q;
	assign status = st_q;
	assign bid_valid = bb_v_q;
	assign bid_price = bb_v_q ? bb_p_q : 32'd0;
	assign bid_total = bb_v_q ? bb_t_q : 40'd0;
	assign bid_orders = bb_v_q ? 9'(bb_c_q) : 9'd0;
	assign ask_valid = ba_v_q;
	assign ask_price = ba_v_q ? ba_p_q : 32'd0;
	assign ask_total = ba_v_q ? ba_t_q : 40'd0;
	assign ask_orders = ba_v_q ? 9'(ba_c_q) : 9'd0;
	assign applied_count = evt_q;
	assign live_orders = 9'(live_q);

	// ------------------------------------------------------------------
	// Checks
	`LOB_ASSERT_IMPL(a_done_busy, done, busy)
	`LOB_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`LOB_ASSERT_NEXT(a_busy_hold, busy && !done, busy)
	`LOB_ASSERT_NEXT(a_done_idle, done, !busy)

endmodule

// ===== tb/sv/limit_order_book_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_update_tb
// Drives add, modify, cancel and execute events into the order book and
// checks every result against a behavioral book kept in the testbench.
// A directed pass covers field extremes and all rejection codes but capacity.
// Random passes follow: mixed traffic, then a fill of both tables to
// capacity, then a drain. Start is raised after random gaps, some of them long.
// ----------------------------------------------------------------------------
module limit_order_book_update_tb;

	localparam int NSLOT = 256;
	localparam int NLVL = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 600;

	typedef struct {
		logic [1:0]  mode;
		logic [63:0] id;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} event_t;

	typedef struct {
		logic [2:0]  status;
		logic        bid_valid;
		logic [31:0] bid_price;
		logic [39:0] bid_total;
		logic [8:0]  bid_orders;
		logic        ask_valid;
		logic [31:0] ask_price;
		logic [39:0] ask_total;
		logic [8:0]  ask_orders;
		logic [63:0] applied_count;
		logic [8:0]  live_orders;
	} book_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = lob_pkg::MODE_ADD;
	logic [63:0] order_ident = '0;
	logic        order_side = 1'b0;
	logic [31:0] price_ticks = '0;
	logic [31:0] amount = '0;
	logic        busy, done;
	logic [2:0]  status;
	logic        bid_valid, ask_valid;
	logic [31:0] bid_price, ask_price;
	logic [39:0] bid_total, ask_total;
	logic [8:0]  bid_orders, ask_orders, live_orders;
	logic [63:0] applied_count;

	limit_order_book_update u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.mode(mode), .order_ident(order_ident), .order_side(order_side),
		.price_ticks(price_ticks), .amount(amount), .status(status),
		.bid_valid(bid_valid), .bid_price(bid_price), .bid_total(bid_total),
		.bid_orders(bid_orders), .ask_valid(ask_valid), .ask_price(ask_price),
		.ask_total(ask_total), .ask_orders(ask_orders),
		.applied_count(applied_count), .live_orders(live_orders)
	);

	always #1 clk = ~clk;

	// shadow book
	bit          sh_used [NSLOT];
	logic [63:0] sh_key [NSLOT];
	logic        sh_side [NSLOT];
	logic [31:0] sh_price [NSLOT];
	logic [31:0] sh_amt [NSLOT];
	bit          lv_used [2*NLVL];
	logic [31:0] lv_price [2*NLVL];
	logic [63:0] lv_total [2*NLVL];
	int unsigned lv_count [2*NLVL];
	logic [63:0] applied_sh = '0;
	int unsigned live_sh = 0;

	event_t       pending_events [$];
	book_report_t expected_reports [$];
	logic [63:0]  known_ids [$];
	int           errors = 0;
	int           gap_left = 0;
	int           idle_cycles = 0;

	function automatic int slot_of(logic [63:0] key);
		for (int i = 0; i < NSLOT; i++)
			if (sh_used[i] && sh_key[i] == key) return i;
		return -1;
	endfunction

	function automatic int level_of(logic side, logic [31:0] price);
		int base;
		base = side ? NLVL : 0;
		for (int i = base; i < base + NLVL; i++)
			if (lv_used[i] && lv_price[i] == price) return i;
		return -1;
	endfunction

	function automatic void level_take(int lv, logic [63:0] q);
		if (lv >= 0) lv_total[lv] -= (lv_total[lv] >= q) ? q : lv_total[lv];
	endfunction

	function automatic void drop_order(int s);
		int lv;
		lv = level_of(sh_side[s], sh_price[s]);
		if (lv >= 0) begin
			level_take(lv, {32'd0, sh_amt[s]});
			if (lv_count[lv] > 0) lv_count[lv]--;
			if (lv_count[lv] == 0) lv_used[lv] = 0;
		end
		sh_used[s] = 0;
		if (live_sh > 0) live_sh--;
	endfunction

	function automatic logic [2:0] apply_event(event_t ev);
		int s, f, lv;
		if (ev.mode != lob_pkg::MODE_CANCEL && ev.qty == 0) return lob_pkg::ST_BADQTY;
		s = slot_of(ev.id);
		case (ev.mode)
			lob_pkg::MODE_ADD: begin
				if (s >= 0) return lob_pkg::ST_DUP;
				f = -1;
				for (int i = 0; i < NSLOT && f < 0; i++) if (!sh_used[i]) f = i;
				if (f < 0) return lob_pkg::ST_CAPACITY;
				lv = level_of(ev.side, ev.price);
				if (lv < 0) begin
					for (int i = 0; i < NLVL && lv < 0; i++)
						if (!lv_used[(ev.side ? NLVL : 0) + i]) lv = (ev.side ? NLVL : 0) + i;
					if (lv < 0) return lob_pkg::ST_CAPACITY;
					lv_used[lv] = 1;
					lv_price[lv] = ev.price;
					lv_total[lv] = 0;
					lv_count[lv] = 0;
				end
				lv_total[lv] += ev.qty;
				lv_count[lv]++;
				sh_used[f] = 1;
				sh_key[f] = ev.id;
				sh_side[f] = ev.side;
				sh_price[f] = ev.price;
				sh_amt[f] = ev.qty;
				live_sh++;
			end
			lob_pkg::MODE_MODIFY: begin
				if (s < 0) return lob_pkg::ST_MISSING;
				if (ev.qty > sh_amt[s]) return lob_pkg::ST_UPMOD;
				if (ev.qty < sh_amt[s]) begin
					level_take(level_of(sh_side[s], sh_price[s]), {32'd0, sh_amt[s] - ev.qty});
					sh_amt[s] = ev.qty;
				end
			end
			lob_pkg::MODE_CANCEL: begin
				if (s < 0) return lob_pkg::ST_MISSING;
				drop_order(s);
			end
			default: begin
				if (s < 0) return lob_pkg::ST_MISSING;
				if (ev.qty > sh_amt[s]) return lob_pkg::ST_SHORT;
				if (ev.qty == sh_amt[s]) drop_order(s);
				else begin
					level_take(level_of(sh_side[s], sh_price[s]), {32'd0, ev.qty});
					sh_amt[s] -= ev.qty;
				end
			end
		endcase
		return lob_pkg::ST_APPLIED;
	endfunction

	// expected report after one event
	function automatic book_report_t predict_report(event_t ev);
		book_report_t r;
		int bb, ba;
		r.status = apply_event(ev);
		if (r.status == lob_pkg::ST_APPLIED) applied_sh++;
		bb = -1;
		ba = -1;
		for (int i = 0; i < NLVL; i++) begin
			if (lv_used[i] && (bb < 0 || lv_price[i] > lv_price[bb])) bb = i;
			if (lv_used[NLVL+i] && (ba < 0 || lv_price[NLVL+i] < lv_price[ba])) ba = NLVL + i;
		end
		r.bid_valid = (bb >= 0);
		r.bid_price = (bb >= 0) ? lv_price[bb] : '0;
		r.bid_total = (bb >= 0) ? lv_total[bb][39:0] : '0;
		r.bid_orders = (bb >= 0) ? lv_count[bb][8:0] : '0;
		r.ask_valid = (ba >= 0);
		r.ask_price = (ba >= 0) ? lv_price[ba] : '0;
		r.ask_total = (ba >= 0) ? lv_total[ba][39:0] : '0;
		r.ask_orders = (ba >= 0) ? lv_count[ba][8:0] : '0;
		r.applied_count = applied_sh;
		r.live_orders = live_sh[8:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
	endtask

	task automatic queue_event(logic [1:0] m, logic [63:0] id, logic sd,
			logic [31:0] pr, logic [31:0] q);
		event_t ev;
		ev.mode = m;
		ev.id = id;
		ev.side = sd;
		ev.price = pr;
		ev.qty = q;
		pending_events = {pending_events, ev};
		if (m == lob_pkg::MODE_ADD) known_ids = {known_ids, id};
	endtask

	function automatic logic [63:0] pick_id();
		if (known_ids.size() > 0 && $urandom_range(99) < 80)
			return known_ids[$urandom_range(known_ids.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] pick_qty();
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 15) return $urandom;
		return $urandom_range(20, 1);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(4, 1);
		return $urandom_range(80, 20);
	endfunction

	task automatic queue_mixed(int n);
		for (int i = 0; i < n; i++)
			queue_event(2'($urandom_range(3)), pick_id(), 1'($urandom_range(1)),
				($urandom_range(9) == 0) ? $urandom : $urandom_range(12, 1), pick_qty());
	endtask

	// driver: one transaction at a time, start held until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				event_t ev;
				book_report_t rep;
				ev.mode = mode;
				ev.id = order_ident;
				ev.side = order_side;
				ev.price = price_ticks;
				ev.qty = amount;
				rep = predict_report(ev);
				expected_reports = {expected_reports, rep};
				start <= 1'b0;
				gap_left <= pick_gap();
			end else if (!start) begin
				if (gap_left > 0) gap_left <= gap_left - 1;
				else if (pending_events.size() > 0) begin
					event_t nx;
					nx = pending_events.pop_front();
					mode <= nx.mode;
					order_ident <= nx.id;
					order_side <= nx.side;
					price_ticks <= nx.price;
					amount <= nx.qty;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected result", 64'd1, 64'd0);
			end else begin
				book_report_t e;
				e = expected_reports.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (bid_valid !== e.bid_valid) report_mismatch("bid_valid", bid_valid, e.bid_valid);
				if (bid_price !== e.bid_price) report_mismatch("bid_price", bid_price, e.bid_price);
				if (bid_total !== e.bid_total) report_mismatch("bid_total", bid_total, e.bid_total);
				if (bid_orders !== e.bid_orders)
					report_mismatch("bid_orders", bid_orders, e.bid_orders);
				if (ask_valid !== e.ask_valid) report_mismatch("ask_valid", ask_valid, e.ask_valid);
				if (ask_price !== e.ask_price) report_mismatch("ask_price", ask_price, e.ask_price);
				if (ask_total !== e.ask_total) report_mismatch("ask_total", ask_total, e.ask_total);
				if (ask_orders !== e.ask_orders)
					report_mismatch("ask_orders", ask_orders, e.ask_orders);
				if (applied_count !== e.applied_count)
					report_mismatch("applied_count", applied_count, e.applied_count);
				if (live_orders !== e.live_orders)
					report_mismatch("live_orders", live_orders, e.live_orders);
			end
		end
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** limit_order_book_update: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		// directed: extremes and every rejection code but capacity
		queue_event(lob_pkg::MODE_ADD, 64'd0, 1'b0, 32'd0, 32'd1);
		queue_event(lob_pkg::MODE_ADD, '1, 1'b1, '1, '1);
		queue_event(lob_pkg::MODE_ADD, 64'd5, 1'b1, '1, '1);
		queue_event(lob_pkg::MODE_ADD, 64'd9, 1'b0, 32'd3, 32'd0);
		queue_event(lob_pkg::MODE_ADD, 64'd0, 1'b1, 32'd7, 32'd4);
		queue_event(lob_pkg::MODE_MODIFY, 64'd5, 1'b0, 32'd0, 32'd0);
		queue_event(lob_pkg::MODE_MODIFY, 64'd77, 1'b0, 32'd0, 32'd3);
		queue_event(lob_pkg::MODE_MODIFY, 64'd5, 1'b0, 32'd0, '1);
		queue_event(lob_pkg::MODE_MODIFY, 64'd0, 1'b0, 32'd0, 32'd2);
		queue_event(lob_pkg::MODE_MODIFY, 64'd5, 1'b0, 32'd0, 32'd1000);
		queue_event(lob_pkg::MODE_EXECUTE, 64'd5, 1'b0, 32'd0, 32'd1001);
		queue_event(lob_pkg::MODE_EXECUTE, 64'd5, 1'b0, 32'd0, 32'd10);
		queue_event(lob_pkg::MODE_EXECUTE, 64'd5, 1'b0, 32'd0, 32'd990);
		queue_event(lob_pkg::MODE_EXECUTE, '1, 1'b0, 32'd0, 32'd0);
		queue_event(lob_pkg::MODE_EXECUTE, 64'd78, 1'b0, 32'd0, 32'd1);
		queue_event(lob_pkg::MODE_CANCEL, 64'd79, 1'b0, 32'd0, '1);
		queue_event(lob_pkg::MODE_CANCEL, 64'd0, 1'b0, 32'd0, 32'd0);
		queue_event(lob_pkg::MODE_ADD, 64'd7, 1'b0, 32'd100, 32'd5);
		queue_event(lob_pkg::MODE_ADD, 64'd8, 1'b0, 32'd200, 32'd6);
		queue_event(lob_pkg::MODE_CANCEL, '1, 1'b1, 32'd0, 32'd0);
		// random mixed traffic on a small price range
		queue_mixed(100);
		// ask side past its level capacity
		for (int i = 0; i < 70; i++) queue_event(lob_pkg::MODE_ADD, {$urandom, $urandom},
			1'b1, 32'd1000 + 3 * i, $urandom_range(50, 1));
		// bid side until the order table is full and beyond
		for (int i = 0; i < 200; i++) queue_event(lob_pkg::MODE_ADD, {$urandom, $urandom},
			1'b0, $urandom_range(8, 1), pick_qty());
		// drain with mostly well-formed cancels and executes
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(3) == 0) queue_mixed(1);
			else queue_event($urandom_range(1) ? lob_pkg::MODE_CANCEL : lob_pkg::MODE_EXECUTE,
				known_ids[$urandom_range(known_ids.size() - 1)], 1'b0, 32'd0,
				$urandom_range(30, 1));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_events.size() > 0 || start || expected_reports.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0)
			$display("** limit_order_book_update: PASSED **");
		else
			$display("** limit_order_book_update: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/lob_pkg.sv
design/limit_order_book_update.sv
tb/sv/limit_order_book_update_tb.sv
